@@ rtl/ttu_pkg.sv @@
`default_nettype none

package ttu_pkg;

  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 13;
  localparam int BASE_W   = 5;

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LX = 8'h78;
  localparam logic [7:0] CHAR_UX = 8'h58;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 13'd8191;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       first_of_string;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  parsed_value;
    logic [OFFSET_W-1:0] end_offset;
  } out_req_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] value;
    logic       is_zero;
    logic       is_x;
  } char_class_t;

endpackage

`default_nettype wire

@@ rtl/text_to_unsigned_parser.sv @@
// Streaming text-to-unsigned converter, one character per request.
// Input channel: in_valid, in_stall and in_req carry one character and a flag
// that marks the first character of a new string. Configuration: cfg_we and
// cfg_wdata write the base register (0 selects hex after 0x/0X, else decimal);
// a new value applies from the next first character.
// Output channel: out_valid, out_stall and out_req give one request per string,
// the value and the characters consumed, when a character is not accepted.
// A character is captured in an input register, then classified and folded into
// the accumulator with one 64 by 5 bit multiply-add once the output is free, and
// the result is registered in the output register when the terminating character
// is folded. One character is accepted every cycle while in_stall is low; the
// accumulator feedback loop through the multiply-add sets that rate.
// While the output register holds an unaccepted request under out_stall, the
// character in the input register waits and in_stall is raised.
// Synchronous reset clears the base to 0 and leaves the converter waiting for
// a first character; characters not marked first are ignored until then.
`default_nettype none

module text_to_unsigned_parser #(
  parameter int MAX_CHARS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ttu_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ttu_pkg::out_req_t      out_req,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_wdata
);
  import ttu_pkg::*;

  localparam logic [OFFSET_W-1:0] OFFSET_CAP =
    (MAX_CHARS < 8191) ? OFFSET_W'(MAX_CHARS) : OFFSET_MAX;

  logic              s1_valid_r, s1_valid_nxt;
  in_req_t           s1_req_r;
  logic [BASE_W-1:0] base_mode_r;
  logic              out_free;
  logic              step;
  char_class_t       cls;

  assign step         = s1_valid_r && out_free;
  assign in_stall     = s1_valid_r && !out_free;
  assign s1_valid_nxt = (in_valid && !in_stall) || (s1_valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      base_mode_r <= BASE_AUTO;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        base_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req;
    end
  end

  ttu_decode u_decode (
    .char_byte (s1_req_r.char_byte),
    .cls       (cls)
  );

  ttu_core #(
    .OFFSET_CAP (OFFSET_CAP)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .first     (s1_req_r.first_of_string),
    .cls       (cls),
    .base_mode (base_mode_r),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r))
    else $error("result appeared without a processed character");

  a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_req.end_offset <= OFFSET_CAP))
    else $error("end offset beyond its saturation limit");

endmodule

`default_nettype wire

@@ rtl/ttu_decode.sv @@
`default_nettype none

module ttu_decode (
  input  wire logic [7:0]          char_byte,
  output ttu_pkg::char_class_t     cls
);
  import ttu_pkg::*;

  always_comb begin
    cls          = '0;
    cls.is_zero  = (char_byte == CHAR_0);
    cls.is_x     = (char_byte == CHAR_LX) || (char_byte == CHAR_UX);
    if (char_byte inside {[CHAR_0:CHAR_9]}) begin
      cls.is_digit = 1'b1;
      cls.value    = 4'(char_byte - CHAR_0);
    end else if (char_byte inside {[CHAR_LA:CHAR_LF]}) begin
      cls.is_digit = 1'b1;
      cls.value    = 4'(char_byte - CHAR_LA + 8'd10);
    end else if (char_byte inside {[CHAR_UA:CHAR_UF]}) begin
      cls.is_digit = 1'b1;
      cls.value    = 4'(char_byte - CHAR_UA + 8'd10);
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttu_core.sv @@
`default_nettype none

module ttu_core #(
  parameter logic [12:0] OFFSET_CAP = 13'd4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  first,
  input  wire ttu_pkg::char_class_t  cls,
  input  wire logic [4:0]            base_mode,
  input  wire logic                  out_stall,
  output logic                       out_free,
  output logic                       out_valid,
  output ttu_pkg::out_req_t          out_req
);
  import ttu_pkg::*;

  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic [OFFSET_W-1:0] cnt_r, cnt_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic                pp_r, pp_nxt;
  logic                stopped_r, stopped_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_req_t            out_req_r, out_req_nxt;

  logic [VALUE_W-1:0]        eff_acc;
  logic [OFFSET_W-1:0]       eff_cnt;
  logic [BASE_W-1:0]         eff_base;
  logic                      do_take;
  logic                      accept_dig;
  logic [VALUE_W+BASE_W-1:0] prod;
  logic [OFFSET_W-1:0]       cnt_inc;
  logic                      result;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  always_comb begin
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    base_nxt    = base_r;
    pp_nxt      = pp_r;
    stopped_nxt = stopped_r;
    eff_acc     = acc_r;
    eff_cnt     = cnt_r;
    eff_base    = base_r;
    do_take     = 1'b0;
    result      = 1'b0;

    if (first) begin
      eff_acc  = '0;
      eff_cnt  = '0;
      eff_base = base_mode;
      pp_nxt   = 1'b0;
      if ((base_mode == BASE_AUTO || base_mode == BASE_HEX) && cls.is_zero) begin
        pp_nxt = 1'b1;
      end else begin
        if (base_mode == BASE_AUTO) begin
          eff_base = BASE_DEC;
        end
        do_take = 1'b1;
      end
    end else if (!stopped_r) begin
      if (pp_r) begin
        pp_nxt = 1'b0;
        if (cls.is_x) begin
          eff_base = BASE_HEX;
        end else begin
          if (base_r == BASE_AUTO) begin
            eff_base = BASE_DEC;
          end
          do_take = 1'b1;
        end
      end else begin
        do_take = 1'b1;
      end
    end

    cnt_inc    = (eff_cnt < OFFSET_CAP) ? eff_cnt + 13'd1 : eff_cnt;
    accept_dig = cls.is_digit && ({1'b0, cls.value} < eff_base);
    prod       = eff_acc * eff_base;

    if (first || !stopped_r) begin
      acc_nxt     = eff_acc;
      base_nxt    = eff_base;
      cnt_nxt     = cnt_inc;
      stopped_nxt = 1'b0;
      if (do_take) begin
        if (accept_dig) begin
          acc_nxt = prod[VALUE_W-1:0] + VALUE_W'(cls.value);
        end else begin
          cnt_nxt     = eff_cnt;
          stopped_nxt = 1'b1;
          result      = 1'b1;
        end
      end
    end

    out_req_nxt.parsed_value = eff_acc;
    out_req_nxt.end_offset   = eff_cnt;

    if (step && result) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      base_r      <= '0;
      pp_r        <= 1'b0;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        acc_r     <= acc_nxt;
        cnt_r     <= cnt_nxt;
        base_r    <= base_nxt;
        pp_r      <= pp_nxt;
        stopped_r <= stopped_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result) begin
      out_req_r <= out_req_nxt;
    end
  end

endmodule

`default_nettype wire
